// ===== src/mlm_pkg.sv =====
// Package for the mutex lock manager: request/response payload types,
// operation and status codes, controller command struct. No dependencies.
`default_nettype none

package mlm_pkg;

  // Default sizes
  localparam int DEF_NUM_MUTEXES = 64;
  localparam int DEF_NUM_THREADS = 64;

  // Operation codes
  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_LOCK    = 2'd1;
  localparam logic [1:0] OP_UNLOCK  = 2'd2;
  localparam logic [1:0] OP_DESTROY = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_NOT_OWNER = 3'd3;
  localparam logic [2:0] ST_BUSY      = 3'd4;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] mutex_num;
    logic [5:0] thread_id;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       granted;
    logic [5:0] new_mutex_id;
    logic       wake_valid;
    logic [5:0] wake_thread;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture request, read table entry
    logic commit;  // write back entry, load response register
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/mlm_ctrl.sv =====
// Controller for the mutex lock manager: two-state sequencer and response valid.
// Depends on mlm_pkg.
`default_nettype none

module mlm_ctrl
  import mlm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output cmd_t      cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic rsp_valid_next;

  assign req_ready = (state == S_IDLE);

  // Decode commands from state and handshakes
  always_comb begin
    cmd.load   = (state == S_IDLE) && req_valid;
    cmd.commit = (state == S_EXEC) && (!rsp_valid || rsp_ready);
  end

  // Advance state, hold in EXEC while the response slot is occupied and not being taken
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Set on commit, drop when taken
  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.commit) rsp_valid_next = 1'b1;
    else if (rsp_ready) rsp_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/mlm_datapath.sv =====
// Datapath for the mutex lock manager: mutex table memory, allocation count,
// request register, entry update logic and response register. Depends on mlm_pkg.
`default_nettype none

module mlm_datapath
  import mlm_pkg::*;
#(
  parameter int NUM_MUTEXES = DEF_NUM_MUTEXES,
  parameter int NUM_THREADS = DEF_NUM_THREADS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  input  wire req_t req,
  output rsp_t      rsp
);

  localparam int IDX_W = $clog2(NUM_MUTEXES);
  localparam int CNT_W = $clog2(NUM_MUTEXES + 1);
  // Entry layout: live, owned, owner[5:0], waiters[NUM_THREADS-1:0]
  localparam int ENT_W = NUM_THREADS + 8;
  localparam int LIVE_B = NUM_THREADS + 7;
  localparam int OWN_B  = NUM_THREADS + 6;
  localparam int OWNR_L = NUM_THREADS;

  logic [ENT_W-1:0] table_mem [NUM_MUTEXES];
  logic [ENT_W-1:0] rdata;
  req_t             req_q;
  logic [CNT_W-1:0] count;

  logic [IDX_W-1:0]       waddr;
  logic [ENT_W-1:0]       wdata;
  logic                   wr_en;
  logic                   bump;
  rsp_t                   rsp_next;
  logic [NUM_THREADS-1:0] tbit;
  logic [NUM_THREADS-1:0] waiters;
  logic                   live;
  logic                   owned;
  logic [5:0]             owner;
  logic                   usable;
  logic                   wfound;
  logic [5:0]             wlow;

  assign live    = rdata[LIVE_B];
  assign owned   = rdata[OWN_B];
  assign owner   = rdata[OWNR_L +: 6];
  assign waiters = rdata[NUM_THREADS-1:0];
  assign usable  = (32'(req_q.mutex_num) < 32'(count)) && live;

  // One-hot bit of the requesting thread, empty when out of range
  always_comb begin
    for (int i = 0; i < NUM_THREADS; i++) begin
      tbit[i] = (32'(req_q.thread_id) == i);
    end
  end

  // Find the lowest-numbered waiter
  always_comb begin
    wfound = 1'b0;
    wlow   = '0;
    for (int i = NUM_THREADS - 1; i >= 0; i--) begin
      if (waiters[i]) begin
        wfound = 1'b1;
        wlow   = 6'(i);
      end
    end
  end

  // Work out the entry update and the response
  always_comb begin
    rsp_next = '0;
    rsp_next.status = ST_OK;
    wr_en = 1'b0;
    bump  = 1'b0;
    waddr = IDX_W'(req_q.mutex_num);
    wdata = rdata;
    if (req_q.operation == OP_CREATE) begin
      if (count >= CNT_W'(NUM_MUTEXES)) begin
        rsp_next.status = ST_FULL;
      end else begin
        wr_en = 1'b1;
        bump  = 1'b1;
        waddr = IDX_W'(count);
        wdata = '0;
        wdata[LIVE_B] = 1'b1;
        rsp_next.new_mutex_id = 6'(count);
      end
    end else if (!usable) begin
      rsp_next.status = ST_INVALID;
    end else begin
      case (req_q.operation)
        OP_LOCK: begin
          wr_en = 1'b1;
          if (!owned || owner == req_q.thread_id) begin
            wdata[OWN_B] = 1'b1;
            wdata[OWNR_L +: 6] = req_q.thread_id;
            wdata[NUM_THREADS-1:0] = waiters & ~tbit;
            rsp_next.granted = 1'b1;
          end else begin
            wdata[NUM_THREADS-1:0] = waiters | tbit;
          end
        end
        OP_UNLOCK: begin
          if (!owned || owner != req_q.thread_id) begin
            rsp_next.status = ST_NOT_OWNER;
          end else begin
            wr_en = 1'b1;
            wdata[OWN_B] = 1'b0;
            wdata[OWNR_L +: 6] = '0;
            rsp_next.wake_valid  = wfound;
            rsp_next.wake_thread = wlow;
          end
        end
        OP_DESTROY: begin
          if (owned) begin
            rsp_next.status = ST_BUSY;
          end else begin
            wr_en = 1'b1;
            wdata[LIVE_B] = 1'b0;
            wdata[NUM_THREADS-1:0] = '0;
          end
        end
        default: rsp_next.status = ST_INVALID;
      endcase
    end
  end

  // Capture the request and read its entry
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
      rdata <= table_mem[IDX_W'(req.mutex_num)];
    end
  end

  // Write back the entry
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) table_mem[waddr] <= wdata;
  end

  // Load the response register
  always_ff @(posedge clk) begin
    if (cmd.commit) rsp <= rsp_next;
  end

  // Advance the allocation count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit && bump) begin
      count <= count + CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== src/mutex_lock_manager_unit.sv =====
// Channel   Signals                         Payload
// request   req_valid / req_ready / req     req_t: operation, mutex_num, thread_id
// response  rsp_valid / rsp_ready / rsp     rsp_t: status, granted, new_mutex_id,
//                                                  wake_valid, wake_thread
//
// Each request is handled as a load step, which reads its table entry from the single
// memory port, then a commit step, which updates the entry and loads the response register.
// A new request is taken while the previous response still waits; a held
// response stalls only the commit of the next request.
// Reset clears the allocation count and the control state; table entries are
// written by create before they can be used, so no clearing pass is needed.
// Top level: joins controller and datapath. Depends on mlm_pkg, mlm_ctrl,
// mlm_datapath.
`default_nettype none

module mutex_lock_manager_unit
  import mlm_pkg::*;
#(
  parameter int NUM_MUTEXES = DEF_NUM_MUTEXES,
  parameter int NUM_THREADS = DEF_NUM_THREADS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  cmd_t cmd;

  mlm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  mlm_datapath #(
    .NUM_MUTEXES (NUM_MUTEXES),
    .NUM_THREADS (NUM_THREADS)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

// ===== src/mlm_checker.sv =====
// Port checker for the mutex lock manager, bound to the top level.
// Depends on mlm_pkg and mutex_lock_manager_unit.
`default_nettype none

module mlm_checker
  import mlm_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp
);

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // One request at a time: ready drops after an accept
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // A grant only comes with ok status
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.granted |-> rsp.status == ST_OK && !rsp.wake_valid)
    else $error("grant with bad status");

  // A wakeup only comes with ok status and no new mutex id
  a_wake_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.wake_valid |-> rsp.status == ST_OK && rsp.new_mutex_id == 6'd0)
    else $error("wakeup with bad status");

endmodule

bind mutex_lock_manager_unit mlm_checker u_mlm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire

// ===== bench/mutex_lock_manager_checker.sv =====
// Response checker for the mutex lock manager: watches the request and response
// channels, keeps its own lock table and compares each response field by field.
// Depends on mlm_pkg.
module mutex_lock_manager_checker
  import mlm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending
);

  localparam int MUTEXES = DEF_NUM_MUTEXES;
  localparam int THREADS = DEF_NUM_THREADS;
  localparam logic [63:0] THREAD_SPAN =
    (THREADS >= 64) ? '1 : ((64'd1 << THREADS) - 64'd1);

  // Shadow lock table
  logic        held [MUTEXES];
  logic [5:0]  holder [MUTEXES];
  logic [63:0] waiters [MUTEXES];
  logic        live [MUTEXES];
  logic [6:0]  handed_out;

  rsp_t expected_replies [$];
  rsp_t want;
  int   errors = 0;

  task automatic flag_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch on %s: got %0d, expected %0d", what, got, exp_val);
    errors++;
  endtask

  // Apply one request to the shadow table and return the response it earns
  function automatic rsp_t lock_table_update(input req_t r);
    rsp_t        o;
    logic [63:0] sel;
    logic [63:0] pool;
    int          m;
    o = '0;
    m = r.mutex_num;
    if (r.operation == OP_CREATE) begin
      if (handed_out >= MUTEXES) begin
        o.status = ST_FULL;
      end else begin
        held[handed_out]    = 1'b0;
        holder[handed_out]  = '0;
        waiters[handed_out] = '0;
        live[handed_out]    = 1'b1;
        o.new_mutex_id      = handed_out[5:0];
        handed_out          = handed_out + 7'd1;
      end
    end else if (!(m < handed_out && live[m])) begin
      o.status = ST_INVALID;
    end else if (r.operation == OP_LOCK) begin
      sel = (r.thread_id < THREADS) ? (64'd1 << r.thread_id) : '0;
      if (!held[m] || holder[m] == r.thread_id) begin
        held[m]    = 1'b1;
        holder[m]  = r.thread_id;
        waiters[m] = waiters[m] & ~sel;
        o.granted  = 1'b1;
      end else begin
        waiters[m] = waiters[m] | sel;
      end
    end else if (r.operation == OP_UNLOCK) begin
      if (!held[m] || holder[m] != r.thread_id) begin
        o.status = ST_NOT_OWNER;
      end else begin
        pool      = waiters[m] & THREAD_SPAN;
        held[m]   = 1'b0;
        holder[m] = '0;
        // scan down so the lowest waiter wins
        for (int i = 63; i >= 0; i--) begin
          if (pool[i]) begin
            o.wake_valid  = 1'b1;
            o.wake_thread = 6'(i);
          end
        end
      end
    end else begin
      if (held[m]) begin
        o.status = ST_BUSY;
      end else begin
        live[m]    = 1'b0;
        waiters[m] = '0;
      end
    end
    return o;
  endfunction

  // Track requests, compare responses
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MUTEXES; i++) begin
        held[i]    = 1'b0;
        holder[i]  = '0;
        waiters[i] = '0;
        live[i]    = 1'b0;
      end
      handed_out = '0;
      expected_replies.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_replies.size() == 0) begin
          flag_mismatch("response with no request outstanding", rsp, 0);
        end else begin
          want = expected_replies.pop_front();
          if (rsp.status !== want.status)
            flag_mismatch("status", rsp.status, want.status);
          if (rsp.granted !== want.granted)
            flag_mismatch("granted", rsp.granted, want.granted);
          if (rsp.new_mutex_id !== want.new_mutex_id)
            flag_mismatch("new_mutex_id", rsp.new_mutex_id, want.new_mutex_id);
          if (rsp.wake_valid !== want.wake_valid)
            flag_mismatch("wake_valid", rsp.wake_valid, want.wake_valid);
          if (rsp.wake_thread !== want.wake_thread)
            flag_mismatch("wake_thread", rsp.wake_thread, want.wake_thread);
        end
      end
      if (req_valid && req_ready) begin
        expected_replies.push_back(lock_table_update(req));
      end
    end
    fail_count <= errors;
    pending    <= expected_replies.size();
  end

endmodule

// ===== bench/mutex_lock_manager_unit_test.sv =====
// Top of the mutex lock manager bench: clock, reset, request stimulus and
// response back-pressure, verdict. Depends on mlm_pkg, mutex_lock_manager_unit
// and mutex_lock_manager_checker.
module mutex_lock_manager_unit_test;
  import mlm_pkg::*;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int fail_count;
  int pending;
  int send_idle  = 14;
  int recv_idle  = 55;
  int ids_handed = 0;

  always #4 clk = ~clk;

  mutex_lock_manager_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  mutex_lock_manager_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Stall the response side at random
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic req_t lock_req(input logic [1:0] op, input int m, input int t);
    req_t r;
    r.operation = op;
    r.mutex_num = 6'(m);
    r.thread_id = 6'(t);
    return r;
  endfunction

  // Hold one request on the channel until it is taken
  task automatic send_request(input req_t item);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (item.operation == OP_CREATE && ids_handed < DEF_NUM_MUTEXES) ids_handed++;
  endtask

  // Mostly lock traffic on recently created mutexes from a few threads
  function automatic req_t pick_request();
    req_t r;
    int   roll;
    int   lo;
    r.operation = 2'($urandom);
    r.mutex_num = 6'($urandom);
    r.thread_id = 6'($urandom);
    roll = $urandom_range(99);
    if (roll < 10) return r;
    if (roll < 17) r.operation = OP_CREATE;
    else if (roll < 59) r.operation = OP_LOCK;
    else if (roll < 94) r.operation = OP_UNLOCK;
    else r.operation = OP_DESTROY;
    if (ids_handed > 0) begin
      lo = (ids_handed > 6) ? ids_handed - 6 : 0;
      r.mutex_num = 6'(lo + $urandom_range(ids_handed - 1 - lo));
    end
    if ($urandom_range(99) < 85) r.thread_id = 6'($urandom_range(3));
    return r;
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Nothing created yet
    send_request(lock_req(OP_LOCK, 0, 0));
    send_request(lock_req(OP_UNLOCK, 63, 63));
    send_request(lock_req(OP_DESTROY, 63, 0));
    // Owner, re-lock by owner, waiters, non-owner unlock, busy destroy
    send_request(lock_req(OP_CREATE, 0, 0));
    send_request(lock_req(OP_LOCK, 0, 0));
    send_request(lock_req(OP_LOCK, 0, 0));
    send_request(lock_req(OP_LOCK, 0, 63));
    send_request(lock_req(OP_LOCK, 0, 5));
    send_request(lock_req(OP_UNLOCK, 0, 5));
    send_request(lock_req(OP_DESTROY, 0, 0));
    // Wake lowest waiter, then unlock of a free mutex
    send_request(lock_req(OP_UNLOCK, 0, 0));
    send_request(lock_req(OP_UNLOCK, 0, 0));
    send_request(lock_req(OP_LOCK, 0, 5));
    send_request(lock_req(OP_UNLOCK, 0, 5));
    send_request(lock_req(OP_LOCK, 0, 42));
    send_request(lock_req(OP_UNLOCK, 0, 42));
    // Retire, then use of a destroyed mutex
    send_request(lock_req(OP_DESTROY, 0, 0));
    send_request(lock_req(OP_LOCK, 0, 63));
    send_request(lock_req(OP_CREATE, 63, 63));
    send_request(lock_req(OP_LOCK, 1, 63));
    send_request(lock_req(OP_UNLOCK, 1, 63));
    send_request(lock_req(OP_DESTROY, 1, 0));
    send_request(lock_req(OP_UNLOCK, 1, 63));
    send_request(lock_req(OP_LOCK, 2, 0));

    repeat (400) send_request(pick_request());
    send_idle = 55;
    recv_idle <= 14;
    repeat (400) send_request(pick_request());
    send_idle = 0;
    recv_idle <= 0;
    repeat (400) send_request(pick_request());
    req_valid <= 1'b0;

    // Drain outstanding responses
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
